@@ hw/rtl/smmh_pkg.sv @@
// ----------------------------------------------------------------------------
// smmh_pkg: shared types and constants
// Field widths, register indexes and the item kind codes of the statistics block.
// ----------------------------------------------------------------------------
package smmh_pkg;

	localparam int SENSORS       = 4;
	localparam int HIST_DEPTH    = 64;
	localparam int HIST_AW       = 6;
	localparam int HIST_CW       = 7;
	localparam int TEMP_W        = 12;
	localparam int SUM_W         = 44;
	localparam int CNT_W         = 32;
	localparam int TIME_W        = 32;

	localparam logic [31:0] STAT_IV_RESET = 32'd2000;
	localparam logic [31:0] HIST_IV_RESET = 32'd60000;

	localparam logic REG_STAT_IV = 1'b0;
	localparam logic REG_HIST_IV = 1'b1;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_STAT = 2'd1;
	localparam logic [1:0] KIND_HIST = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	// per-lane view handed to the merge stage
	typedef struct packed {
		logic signed [TEMP_W-1:0] min_v;
		logic signed [TEMP_W-1:0] max_v;
		logic signed [SUM_W-1:0]  sum_v;
		logic [CNT_W-1:0]         cnt_v;
	} lane_stat_t;

	// tick update request from the top to all lanes
	typedef struct packed {
		logic                     upd;
		logic                     present;
		logic signed [TEMP_W-1:0] temp;
	} lane_upd_t;

endpackage

@@ hw/rtl/smmh_lane.sv @@
// ----------------------------------------------------------------------------
// smmh_lane: statistics for one sensor
// Keeps min, max, a saturating count and the running sum of one sensor.
// ----------------------------------------------------------------------------
module smmh_lane (
	input  logic                    clk,
	input  logic                    arst_n,
	input  smmh_pkg::lane_upd_t     upd,
	output smmh_pkg::lane_stat_t    stat
);

	logic signed [smmh_pkg::TEMP_W-1:0] min_q, max_q;
	logic signed [smmh_pkg::SUM_W-1:0]  sum_q;
	logic [smmh_pkg::CNT_W-1:0]         cnt_q;
	logic                               take;

	assign take = upd.upd && upd.present;

	// min and max need no reset: read only once count is nonzero
	always_ff @(posedge clk) begin
		if (take) begin
			if (cnt_q == '0 || upd.temp < min_q) min_q <= upd.temp;
			if (cnt_q == '0 || upd.temp > max_q) max_q <= upd.temp;
		end
	end

	// sum and count freeze once the count saturates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (take && cnt_q != '1) begin
			sum_q <= sum_q + smmh_pkg::SUM_W'(upd.temp);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign stat.min_v = min_q;
	assign stat.max_v = max_q;
	assign stat.sum_v = sum_q;
	assign stat.cnt_v = cnt_q;

endmodule

@@ hw/rtl/smmh_div.sv @@
// ----------------------------------------------------------------------------
// smmh_div: serial signed divider
// Restoring divide of a 44-bit signed sum by a 32-bit count, one bit a cycle.
// ----------------------------------------------------------------------------
module smmh_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [smmh_pkg::SUM_W-1:0] dividend,
	input  logic [smmh_pkg::CNT_W-1:0]        divisor,
	output logic                              done,
	output logic signed [smmh_pkg::TEMP_W-1:0] quot
);

	localparam int SW = smmh_pkg::SUM_W;
	localparam int CW = smmh_pkg::CNT_W;

	logic [SW-1:0] num_q;
	logic [CW:0]   rem_q;
	logic [CW-1:0] den_q;
	logic          neg_q;
	logic [5:0]    bit_q;
	logic          busy_q;
	logic [CW:0]   trial;
	logic [CW:0]   diff;
	logic [SW-1:0] qmag;

	assign trial = {rem_q[CW-1:0], num_q[SW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			bit_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= 6'(SW - 1);
			end else if (busy_q) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// shift-subtract datapath; quotient bits enter num_q from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SW-1];
			num_q <= dividend[SW-1] ? SW'(-dividend) : dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[CW]) begin
				rem_q <= diff;
				num_q <= {num_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[SW-2:0], 1'b0};
			end
		end
	end

	assign qmag = neg_q ? SW'(-num_q) : num_q;
	assign quot = qmag[smmh_pkg::TEMP_W-1:0];

endmodule

@@ hw/rtl/sensor_min_max_mean_history_top.sv @@
// ----------------------------------------------------------------------------
// sensor_min_max_mean_history_top: sensor statistics and snapshot history
// Four sensor lanes keep running stats; a merge stage selects and divides;
// a ring memory holds timestamped snapshots.
//
//  channel | dir | beat content
//  s_axis  | in  | tdata: kind, now_time, present_mask, temp_a..d, sensor_sel, entry_sel
//  m_axis  | out | tdata: ok, low..mean, stats_valid, stat_ticks, hist_*, hist_filled
//  cfg     | in  | wr_en, wr_idx, wr_data (0 stat interval, 1 history interval)
//
// A tick leaves the input ready.
// A history read captures the ring read with the input beat and then passes
// ST_HRD and ST_OUT before its result beat is valid; a statistics read waits
// for the 44-step serial divider, or has its result beat valid in the cycle
// after the input beat when the sensor has no samples.
// One item is in work at a time; s_axis_tready drops until the result beat
// has left the output register.
// Reset clears sums, counts, tick count and ring pointers and sets the
// intervals to their reset values; the ring contents are left as they are.
// ----------------------------------------------------------------------------
module sensor_min_max_mean_history_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// kind[1:0] now_time[33:2] present_mask[37:34] temp_a[49:38] temp_b[61:50]
	// temp_c[73:62] temp_d[85:74] sensor_sel[87:86] entry_sel[93:88]
	input  logic [95:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// ok[0] low_temp[12:1] high_temp[24:13] mean_temp[36:25] stats_valid[37]
	// stat_ticks[69:38] hist_time[101:70] hist_temp[113:102]
	// hist_present[114] hist_filled[121:115]
	output logic [127:0] m_axis_tdata,
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_idx,
	input  logic [31:0]  cfg_wr_data
);

	localparam int TW = smmh_pkg::TEMP_W;
	localparam int AW = smmh_pkg::HIST_AW;
	localparam int HVW = smmh_pkg::SENSORS * TW + smmh_pkg::SENSORS;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HRD, ST_OUT} st_t;

	st_t st_q;

	logic [1:0]          kind;
	logic [31:0]         now_time;
	logic [3:0]          present_mask;
	logic [TW-1:0]       temps [smmh_pkg::SENSORS];
	logic [1:0]          sensor_sel;
	logic [5:0]          entry_sel;

	assign kind         = s_axis_tdata[1:0];
	assign now_time     = s_axis_tdata[33:2];
	assign present_mask = s_axis_tdata[37:34];
	assign temps[0]     = s_axis_tdata[49:38];
	assign temps[1]     = s_axis_tdata[61:50];
	assign temps[2]     = s_axis_tdata[73:62];
	assign temps[3]     = s_axis_tdata[85:74];
	assign sensor_sel   = s_axis_tdata[87:86];
	assign entry_sel    = s_axis_tdata[93:88];

	logic [31:0] stat_iv_q, hist_iv_q, last_stat_q, last_hist_q, ticks_q;
	logic [AW-1:0] head_q;
	logic [smmh_pkg::HIST_CW-1:0] hcnt_q;

	logic in_beat, is_tick, stat_due, hist_due;
	assign s_axis_tready = (st_q == ST_IDLE) && !m_axis_tvalid;
	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign is_tick  = in_beat && kind == smmh_pkg::KIND_TICK;
	assign stat_due = (now_time - last_stat_q) >= stat_iv_q;
	assign hist_due = (now_time - last_hist_q) >= hist_iv_q;

	// sensor lanes
	smmh_pkg::lane_upd_t  upd  [smmh_pkg::SENSORS];
	smmh_pkg::lane_stat_t stat [smmh_pkg::SENSORS];
	for (genvar g = 0; g < smmh_pkg::SENSORS; g++) begin : g_lane
		assign upd[g].upd     = is_tick && stat_due;
		assign upd[g].present = present_mask[g];
		assign upd[g].temp    = temps[g];
		smmh_lane u_lane (.clk(clk), .arst_n(arst_n), .upd(upd[g]), .stat(stat[g]));
	end

	// configuration and tick bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_iv_q   <= smmh_pkg::STAT_IV_RESET;
			hist_iv_q   <= smmh_pkg::HIST_IV_RESET;
			last_stat_q <= '0;
			last_hist_q <= '0;
			ticks_q     <= '0;
			head_q      <= '0;
			hcnt_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_wr_idx == smmh_pkg::REG_STAT_IV) stat_iv_q <= cfg_wr_data;
				else hist_iv_q <= cfg_wr_data;
			end
			if (is_tick && stat_due) begin
				last_stat_q <= now_time;
				if (present_mask != '0 && ticks_q != '1) ticks_q <= ticks_q + 1'b1;
			end
			if (is_tick && hist_due) begin
				last_hist_q <= now_time;
				head_q      <= head_q + 1'b1;
				if (hcnt_q != smmh_pkg::HIST_CW'(smmh_pkg::HIST_DEPTH))
					hcnt_q <= hcnt_q + 1'b1;
			end
		end
	end

	// snapshot ring: one write port, one registered read port
	logic [31:0]    ring_t [smmh_pkg::HIST_DEPTH];
	logic [HVW-1:0] ring_v [smmh_pkg::HIST_DEPTH];
	logic [HVW-1:0] snap;
	logic [31:0]    rd_t_q;
	logic [HVW-1:0] rd_v_q;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;

	always_comb begin
		snap = '0;
		for (int s = 0; s < smmh_pkg::SENSORS; s++) begin
			if (present_mask[s]) begin
				snap[s*TW +: TW] = temps[s];
				snap[smmh_pkg::SENSORS*TW + s] = 1'b1;
			end
		end
	end

	assign wr_addr = head_q + 1'b1;
	assign rd_addr = head_q - entry_sel;

	// read data is captured with the input beat and held while the read is in work
	always_ff @(posedge clk) begin
		if (is_tick && hist_due) begin
			ring_t[wr_addr] <= now_time;
			ring_v[wr_addr] <= snap;
		end
		if (in_beat) begin
			rd_t_q <= ring_t[rd_addr];
			rd_v_q <= ring_v[rd_addr];
		end
	end

	// merge stage: selected lane into the divider
	smmh_pkg::lane_stat_t sel_stat;
	logic div_start, div_done;
	logic signed [TW-1:0] quot;
	assign sel_stat  = stat[sensor_sel];
	assign div_start = in_beat && kind == smmh_pkg::KIND_STAT && sel_stat.cnt_v != '0;

	smmh_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(sel_stat.sum_v), .divisor(sel_stat.cnt_v),
		.done(div_done), .quot(quot)
	);

	// sequencer and output register
	logic [1:0] sel_q;
	logic       hok_q;
	logic       hist_hit;
	logic [TW-1:0] hist_tv;
	logic [31:0]   hist_tm;

	assign hist_hit = hok_q && rd_v_q[smmh_pkg::SENSORS*TW + sel_q];
	assign hist_tv  = hist_hit ? rd_v_q[sel_q*TW +: TW] : '0;
	assign hist_tm  = hok_q ? rd_t_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			sel_q         <= '0;
			hok_q         <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_beat) begin
						sel_q <= sensor_sel;
						hok_q <= {1'b0, entry_sel} < hcnt_q;
						// hist_filled, stat_ticks and ok; other fields start at zero
						m_axis_tdata <= {6'd0, hcnt_q, 45'd0, ticks_q, 37'd0,
							kind == smmh_pkg::KIND_STAT};
						case (kind)
							smmh_pkg::KIND_STAT: begin
								if (sel_stat.cnt_v != '0) st_q <= ST_DIV;
								else m_axis_tvalid <= 1'b1;
							end
							smmh_pkg::KIND_HIST: st_q <= ST_HRD;
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						m_axis_tdata[37:1] <= {1'b1, quot, stat[sel_q].max_v,
							stat[sel_q].min_v};
						m_axis_tvalid      <= 1'b1;
						st_q               <= ST_IDLE;
					end
				end
				ST_HRD: st_q <= ST_OUT;
				ST_OUT: begin
					m_axis_tdata[114:0] <= {hist_hit, hist_tv, hist_tm,
						m_axis_tdata[69:1], hok_q};
					m_axis_tvalid <= 1'b1;
					st_q          <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ dv/sensor_min_max_mean_history_top_tb.sv @@
// ----------------------------------------------------------------------------
// sensor_min_max_mean_history_top_tb: self-checking bench for the stats block
// Drives tick, statistics-read, history-read and no-op beats through the input
// stream and models the running min/max/mean and the snapshot ring. Every
// result beat is compared against the oldest predicted one.
// Phases vary the interval registers and the sender and receiver idling.
// ----------------------------------------------------------------------------
module sensor_min_max_mean_history_top_tb;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] now_time;
		logic [3:0]  present_mask;
		logic [11:0] temp_a;
		logic [11:0] temp_b;
		logic [11:0] temp_c;
		logic [11:0] temp_d;
		logic [1:0]  sensor_sel;
		logic [5:0]  entry_sel;
	} sample_beat_t;

	typedef struct packed {
		logic        ok;
		logic [11:0] low_temp;
		logic [11:0] high_temp;
		logic [11:0] mean_temp;
		logic        stats_valid;
		logic [31:0] stat_ticks;
		logic [31:0] hist_time;
		logic [11:0] hist_temp;
		logic        hist_present;
		logic [6:0]  hist_filled;
	} report_beat_t;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 2000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [95:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic         cfg_wr_en;
	logic         cfg_wr_idx;
	logic [31:0]  cfg_wr_data;

	sensor_min_max_mean_history_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_idx(cfg_wr_idx), .cfg_wr_data(cfg_wr_data)
	);

	// predictor state
	logic [31:0] stat_iv, hist_iv;
	logic signed [11:0] lo_temp [smmh_pkg::SENSORS] = '{default: '0};
	logic signed [11:0] hi_temp [smmh_pkg::SENSORS] = '{default: '0};
	logic signed [43:0] temp_sum [smmh_pkg::SENSORS] = '{default: '0};
	logic [31:0] temp_cnt [smmh_pkg::SENSORS] = '{default: '0};
	logic [31:0] upd_ticks = '0;
	logic [31:0] last_stat_ms = '0;
	logic [31:0] last_hist_ms = '0;
	logic [31:0] ring_time [smmh_pkg::HIST_DEPTH];
	logic [11:0] ring_temp [smmh_pkg::HIST_DEPTH][smmh_pkg::SENSORS];
	logic [3:0]  ring_mask [smmh_pkg::HIST_DEPTH];
	logic [5:0]  ring_head = '0;
	logic [6:0]  ring_fill = '0;

	sample_beat_t pending_beats[$];
	report_beat_t expected_reports[$];
	int  mismatches = 0;
	int  cycles = 0;
	int  send_idle_pct, recv_stall_pct;
	bit  in_taken = 1'b0;
	bit  hold_go = 1'b0;
	bit  hold_recv = 1'b0;
	int  hold_count = 0;
	bit  send_paused;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input report_beat_t got,
			input report_beat_t want);
		mismatches++;
		$display("mismatch %s: got %0h expected %0h (t=%0t)", what, got, want, $time);
	endtask

	function automatic logic [11:0] beat_temp(input sample_beat_t b, input int s);
		case (s)
			0: beat_temp = b.temp_a;
			1: beat_temp = b.temp_b;
			2: beat_temp = b.temp_c;
			default: beat_temp = b.temp_d;
		endcase
	endfunction

	// kind sits in the lowest bits of tdata
	function automatic logic [95:0] pack_beat(input sample_beat_t b);
		pack_beat = {2'b00, b.entry_sel, b.sensor_sel, b.temp_d, b.temp_c, b.temp_b,
			b.temp_a, b.present_mask, b.now_time, b.kind};
	endfunction

	task automatic predict_stats(input sample_beat_t b);
		report_beat_t r;
		logic signed [11:0] t;
		logic signed [43:0] quot;
		logic [5:0] slot;
		bit any;
		r = '0;
		if (b.kind == smmh_pkg::KIND_TICK) begin
			if (b.now_time - last_stat_ms >= stat_iv) begin
				any = 0;
				last_stat_ms = b.now_time;
				for (int s = 0; s < smmh_pkg::SENSORS; s++) begin
					if (b.present_mask[s]) begin
						t = beat_temp(b, s);
						if (temp_cnt[s] == 0 || t < lo_temp[s]) lo_temp[s] = t;
						if (temp_cnt[s] == 0 || t > hi_temp[s]) hi_temp[s] = t;
						if (temp_cnt[s] != 32'hFFFF_FFFF) begin
							temp_sum[s] = temp_sum[s] + t;
							temp_cnt[s] = temp_cnt[s] + 32'd1;
						end
						any = 1;
					end
				end
				if (any && upd_ticks != 32'hFFFF_FFFF) upd_ticks++;
			end
			if (b.now_time - last_hist_ms >= hist_iv) begin
				last_hist_ms = b.now_time;
				ring_head = ring_head + 6'd1;
				ring_time[ring_head] = b.now_time;
				ring_mask[ring_head] = b.present_mask;
				for (int s = 0; s < smmh_pkg::SENSORS; s++)
					ring_temp[ring_head][s] = b.present_mask[s] ? beat_temp(b, s) : 12'd0;
				if (ring_fill < smmh_pkg::HIST_DEPTH) ring_fill++;
			end
			return;
		end
		if (b.kind == smmh_pkg::KIND_NONE) return;
		r.stat_ticks = upd_ticks;
		r.hist_filled = ring_fill;
		if (b.kind == smmh_pkg::KIND_STAT) begin
			r.ok = 1'b1;
			if (temp_cnt[b.sensor_sel] != 0) begin
				quot = temp_sum[b.sensor_sel] / $signed({12'd0, temp_cnt[b.sensor_sel]});
				r.low_temp = lo_temp[b.sensor_sel];
				r.high_temp = hi_temp[b.sensor_sel];
				r.mean_temp = quot[11:0];
				r.stats_valid = 1'b1;
			end
		end else if (b.entry_sel < ring_fill) begin
			slot = ring_head - b.entry_sel;
			r.ok = 1'b1;
			r.hist_time = ring_time[slot];
			if (ring_mask[slot][b.sensor_sel]) begin
				r.hist_temp = ring_temp[slot][b.sensor_sel];
				r.hist_present = 1'b1;
			end
		end
		expected_reports.push_back(r);
	endtask

	// input handshake seen at the rising edge
	always @(posedge clk) begin
		in_taken <= s_axis_tvalid && s_axis_tready;
	end

	// driver: offers queued beats, changes at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				// accepted at the last rising edge; predict it now
				predict_stats(pending_beats.pop_front());
			end
			// a waiting beat stays as it is until accepted
			if (!s_axis_tvalid || in_taken) begin
				if (pending_beats.size() != 0 && !send_paused &&
						$urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pack_beat(pending_beats[0]);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: compares each result beat with the oldest expectation
	always @(posedge clk) begin
		report_beat_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.ok = m_axis_tdata[0];
			got.low_temp = m_axis_tdata[12:1];
			got.high_temp = m_axis_tdata[24:13];
			got.mean_temp = m_axis_tdata[36:25];
			got.stats_valid = m_axis_tdata[37];
			got.stat_ticks = m_axis_tdata[69:38];
			got.hist_time = m_axis_tdata[101:70];
			got.hist_temp = m_axis_tdata[113:102];
			got.hist_present = m_axis_tdata[114];
			got.hist_filled = m_axis_tdata[121:115];
			if (expected_reports.size() == 0) begin
				report_mismatch("unexpected beat", got, '0);
			end else begin
				want = expected_reports.pop_front();
				if (got !== want) report_mismatch("result beat", got, want);
			end
		end
	end

	// long receiver hold-off, counted here
	always @(negedge clk) begin
		if (hold_go && hold_count < HOLD_CYCLES) begin
			hold_count <= hold_count + 1;
			hold_recv <= 1'b1;
		end else begin
			hold_recv <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL sensor_min_max_mean_history_top");
			$finish;
		end
	end

	function automatic sample_beat_t make_beat(input logic [1:0] kind,
			input logic [31:0] now_ms, input logic [3:0] mask, input logic [11:0] ta,
			input logic [11:0] tb, input logic [11:0] tc, input logic [11:0] td,
			input logic [1:0] sel, input logic [5:0] entry);
		sample_beat_t b;
		b.kind = kind; b.now_time = now_ms; b.present_mask = mask;
		b.temp_a = ta; b.temp_b = tb; b.temp_c = tc; b.temp_d = td;
		b.sensor_sel = sel; b.entry_sel = entry;
		make_beat = b;
	endfunction

	// random read mostly picks a filled ring entry, at times one beyond the fill
	function automatic logic [5:0] pick_entry();
		if (ring_fill < smmh_pkg::HIST_DEPTH && $urandom_range(3) == 0)
			pick_entry = 6'($urandom_range(63, ring_fill));
		else if (ring_fill != 0)
			pick_entry = 6'($urandom_range(ring_fill - 1));
		else
			pick_entry = 6'($urandom_range(63));
	endfunction

	task automatic wait_drained();
		while (pending_beats.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
			@(posedge clk);
		// a trailing tick may still be in work
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1; cfg_wr_idx <= idx; cfg_wr_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == smmh_pkg::REG_STAT_IV) stat_iv = val; else hist_iv = val;
	endtask

	// one random run of beats; ticks advance a clock by random steps or by small multiples of the stat interval
	task automatic random_run(input int count, inout logic [31:0] clock_ms);
		logic [1:0] k;
		logic [31:0] step;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: k = smmh_pkg::KIND_TICK;
				5, 6: k = smmh_pkg::KIND_STAT;
				7, 8: k = smmh_pkg::KIND_HIST;
				default: k = ($urandom_range(3) == 0) ? smmh_pkg::KIND_NONE :
					smmh_pkg::KIND_HIST;
			endcase
			case ($urandom_range(3))
				0: step = $urandom;
				1: step = $urandom_range(3000);
				default: step = $urandom_range(2) * (stat_iv > 100000 ? 32'd1 : stat_iv);
			endcase
			if (k == smmh_pkg::KIND_TICK) clock_ms += step;
			pending_beats.push_back(make_beat(k,
				k == smmh_pkg::KIND_TICK ? clock_ms : $urandom,
				4'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
				2'($urandom), 6'($urandom)));
			// keep entry selection legal with respect to the prediction at issue
			while (pending_beats.size() > 4) @(posedge clk);
			if (pending_beats[pending_beats.size()-1].kind == smmh_pkg::KIND_HIST)
				pending_beats[pending_beats.size()-1].entry_sel = pick_entry();
		end
	endtask

	initial begin
		logic [31:0] clock_ms;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0; cfg_wr_idx = smmh_pkg::REG_STAT_IV; cfg_wr_data = '0;
		send_paused = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		stat_iv = smmh_pkg::STAT_IV_RESET; hist_iv = smmh_pkg::HIST_IV_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset intervals, reads before any sample, extremes
		pending_beats.push_back(make_beat(smmh_pkg::KIND_STAT, '0, '0, '0, '0, '0, '0,
			2'd3, '0));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_HIST, '0, '0, '0, '0, '0, '0,
			2'd0, 6'd0));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_HIST, '0, '0, '0, '0, '0, '0,
			2'd1, 6'd63));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_TICK, 32'd1999, 4'hF, 12'h7FF,
			12'h800, 12'h000, 12'hFFF, '0, '0));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_TICK, 32'd2000, 4'hF, 12'h7FF,
			12'h800, 12'h000, 12'hFFF, '0, '0));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_TICK, 32'd4000, 4'h5, 12'h800,
			12'h7FF, 12'h001, 12'h801, '0, '0));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_TICK, 32'd4500, 4'hF, 12'h123,
			12'h456, 12'h789, 12'hABC, '0, '0));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_TICK, 32'd60000, 4'hA, 12'h7FF,
			12'h800, 12'hFFF, 12'h001, '0, '0));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_TICK, 32'd64000, 4'h0, 12'h555,
			12'hAAA, 12'h555, 12'hAAA, '0, '0));
		for (int s = 0; s < smmh_pkg::SENSORS; s++)
			pending_beats.push_back(make_beat(smmh_pkg::KIND_STAT, $urandom, 4'hF, '0, '0,
				'0, '0, 2'(s), '0));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_HIST, '0, '0, '0, '0, '0, '0,
			2'd1, 6'd0));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_HIST, '0, '0, '0, '0, '0, '0,
			2'd0, 6'd0));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_HIST, '0, '0, '0, '0, '0, '0,
			2'd2, 6'd1));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_NONE, 32'hFFFF_FFFF, 4'hF, 12'hFFF,
			12'hFFF, 12'hFFF, 12'hFFF, 2'd3, 6'd63));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_TICK, 32'hFFFF_FFFF, 4'hF, 12'h7FF,
			12'h7FF, 12'h7FF, 12'h7FF, '0, '0));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_TICK, 32'd5, 4'hF, 12'h800, 12'h800,
			12'h800, 12'h800, '0, '0));
		pending_beats.push_back(make_beat(smmh_pkg::KIND_STAT, '0, '0, '0, '0, '0, '0,
			2'd3, '0));
		wait_drained();
		clock_ms = 32'd10;

		// phase A: tight intervals, no idling
		write_reg(smmh_pkg::REG_STAT_IV, 32'd1);
		write_reg(smmh_pkg::REG_HIST_IV, 32'd1);
		random_run(450, clock_ms);
		wait_drained();

		// phase B: sender idles, huge history interval, long receiver hold-off
		write_reg(smmh_pkg::REG_STAT_IV, 32'd1500);
		write_reg(smmh_pkg::REG_HIST_IV, 32'hFFFF_FFFF);
		send_idle_pct = 73;
		hold_go = 1'b1;
		random_run(450, clock_ms);
		wait_drained();

		// phase C: receiver stalls, sender pauses until drained mid-run
		write_reg(smmh_pkg::REG_STAT_IV, 32'hFFFF_FFFF);
		write_reg(smmh_pkg::REG_HIST_IV, 32'd700);
		send_idle_pct = 0; recv_stall_pct = 73;
		random_run(200, clock_ms);
		send_paused = 1;
		while (expected_reports.size() != 0 || s_axis_tvalid) @(posedge clk);
		send_paused = 0;
		random_run(250, clock_ms);
		wait_drained();

		// phase D: both idle, reset stat interval, tight history interval
		write_reg(smmh_pkg::REG_STAT_IV, 32'd2000);
		write_reg(smmh_pkg::REG_HIST_IV, 32'd1);
		send_idle_pct = 21; recv_stall_pct = 21;
		random_run(450, clock_ms);
		wait_drained();

		if (mismatches == 0)
			$display("PASS sensor_min_max_mean_history_top");
		else
			$display("FAIL sensor_min_max_mean_history_top");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/smmh_pkg.sv
hw/rtl/smmh_lane.sv
hw/rtl/smmh_div.sv
hw/rtl/sensor_min_max_mean_history_top.sv
dv/sensor_min_max_mean_history_top_tb.sv
